### src/zmvu_pkg.sv
// ============================================================================
// zmvu_pkg
// Shared types, codes and defaults for the Z-machine memory and variable unit.
// ============================================================================
`default_nettype none

package zmvu_pkg;

    // Default sizes
    localparam int DEF_MEM_BYTES   = 524288;
    localparam int DEF_STACK_DEPTH = 1023;
    localparam int DEF_LOCAL_COUNT = 15;

    localparam int CFG_W  = 20;
    localparam int PTR_W  = 20;
    localparam int DATA_W = 19;

    // Operation codes
    localparam logic [2:0] OP_LOAD     = 3'd0;
    localparam logic [2:0] OP_RD_BYTE  = 3'd1;
    localparam logic [2:0] OP_RD_WORD  = 3'd2;
    localparam logic [2:0] OP_WR_BYTE  = 3'd3;
    localparam logic [2:0] OP_WR_WORD  = 3'd4;
    localparam logic [2:0] OP_RD_VAR   = 3'd5;
    localparam logic [2:0] OP_WR_VAR   = 3'd6;
    localparam logic [2:0] OP_UNPACK   = 3'd7;

    // Error codes
    localparam logic [2:0] ERR_OK     = 3'd0;
    localparam logic [2:0] ERR_BOUNDS = 3'd1;
    localparam logic [2:0] ERR_ZERO   = 3'd2;
    localparam logic [2:0] ERR_EMPTY  = 3'd3;
    localparam logic [2:0] ERR_FULL   = 3'd4;

    // Story memory address select
    localparam logic [2:0] SEL_PTR     = 3'd0;
    localparam logic [2:0] SEL_PTR1    = 3'd1;
    localparam logic [2:0] SEL_BASE_HI = 3'd2;
    localparam logic [2:0] SEL_BASE_LO = 3'd3;
    localparam logic [2:0] SEL_ZERO    = 3'd4;

    // Result select
    localparam logic [2:0] RES_ZERO   = 3'd0;
    localparam logic [2:0] RES_BYTE   = 3'd1;
    localparam logic [2:0] RES_WORD   = 3'd2;
    localparam logic [2:0] RES_STACK  = 3'd3;
    localparam logic [2:0] RES_LOCAL  = 3'd4;
    localparam logic [2:0] RES_UNPACK = 3'd5;

    // Header word holding the globals table base
    localparam logic [PTR_W-1:0] GLOBAL_BASE = 20'd12;

    typedef struct packed {
        logic [2:0]  op;
        logic [18:0] address;
        logic [7:0]  variable;
        logic [15:0] value;
    } t_in;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [2:0]        error;
    } t_out;

    typedef struct packed {
        logic       load;
        logic       mem_rd;
        logic       mem_wr;
        logic [2:0] addr_sel;
        logic       byte_hi;
        logic       cap_hi;
        logic       cap_ptr;
        logic       stk_push;
        logic       stk_pop;
        logic       loc_wr;
        logic       fin;
        logic [2:0] res_sel;
        logic [2:0] err;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       ptr_zero;
        logic       ptr_in_mem;
        logic       ptr_byte_ok;
        logic       ptr_word_ok;
        logic       var_stack;
        logic       var_local;
        logic       local_ok;
        logic       stk_empty;
        logic       stk_full;
        logic       base_ok;
        logic       rev_ok;
    } t_sts;

endpackage

`default_nettype wire

### src/zmachine_memory_variable_unit_top.sv
// ============================================================================
// zmachine_memory_variable_unit_top
// Z-machine story memory and variable unit: byte/word access and variables.
// ============================================================================
// Pulse start with a command word while busy is low; busy rises on the next
// cycle and the block works on that one word. The result word appears on
// o_out for exactly one cycle with o_valid high, and the receiver cannot hold
// it off, so capture it when o_valid is seen. busy is already low in that
// same cycle, so a new command may be issued alongside the result. Load, byte
// write, local access, stack push and every error found at decode finish in
// the decode state; byte read, stack pop and unpack go on through S_RB, S_SP
// or S_UN, word write through S_WL, word read through S_W1 and S_W2. A global
// reads the base in decode and S_G1, forms its address in S_G2, checks it in
// S_G3 and ends there on a failure, else goes on as a word access. Commands
// never overlap. The pace is set by the single byte-wide port of the story
// memory: a word needs two accesses, and a global first fetches the table
// base word from the header before it touches the variable itself. The
// ram_size register (i_cfg_we / i_cfg_wdata) is clamped to the memory size
// when written; write it only while the block is idle. Story memory and the
// evaluation stack power up undefined and are not cleared; locals and the
// stack count reset to zero.
// ============================================================================
`default_nettype none

module zmachine_memory_variable_unit_top #(
    parameter int MEM_BYTES   = zmvu_pkg::DEF_MEM_BYTES,
    parameter int STACK_DEPTH = zmvu_pkg::DEF_STACK_DEPTH,
    parameter int LOCAL_COUNT = zmvu_pkg::DEF_LOCAL_COUNT
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // command word
    input  wire logic                       start,
    output logic                            busy,
    input  wire zmvu_pkg::t_in              i_in,
    // ram_size register
    input  wire logic                       i_cfg_we,
    input  wire logic [zmvu_pkg::CFG_W-1:0] i_cfg_wdata,
    // result word
    output logic                            o_valid,
    output zmvu_pkg::t_out                  o_out
);

    zmvu_pkg::t_cmd w_cmd;
    zmvu_pkg::t_sts w_sts;

    // Sequencer: accept, decode, step memory accesses, finish
    zmvu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Storage, bounds checks and result register
    zmvu_dp #(
        .MEM_BYTES   (MEM_BYTES),
        .STACK_DEPTH (STACK_DEPTH),
        .LOCAL_COUNT (LOCAL_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_valid     (o_valid),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

### src/zmvu_ctrl.sv
// ============================================================================
// zmvu_ctrl
// Operation sequencer: decodes the latched word and steps the datapath.
// ============================================================================
`default_nettype none

module zmvu_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire zmvu_pkg::t_sts i_sts,
    output zmvu_pkg::t_cmd     o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_RB   = 4'd2;
    localparam logic [3:0] S_W1   = 4'd3;
    localparam logic [3:0] S_W2   = 4'd4;
    localparam logic [3:0] S_WL   = 4'd5;
    localparam logic [3:0] S_SP   = 4'd6;
    localparam logic [3:0] S_G1   = 4'd7;
    localparam logic [3:0] S_G2   = 4'd8;
    localparam logic [3:0] S_G3   = 4'd9;
    localparam logic [3:0] S_UN   = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_IDLE;
                case (i_sts.op)
                    zmvu_pkg::OP_LOAD: begin
                        o_cmd.fin = 1'b1;
                        if (i_sts.ptr_in_mem) begin
                            o_cmd.mem_wr   = 1'b1;
                            o_cmd.addr_sel = zmvu_pkg::SEL_PTR;
                        end else begin
                            o_cmd.err = zmvu_pkg::ERR_BOUNDS;
                        end
                    end
                    zmvu_pkg::OP_RD_BYTE: begin
                        if (i_sts.ptr_byte_ok) begin
                            o_cmd.mem_rd   = 1'b1;
                            o_cmd.addr_sel = zmvu_pkg::SEL_PTR;
                            n_state        = S_RB;
                        end else begin
                            o_cmd.fin = 1'b1;
                            o_cmd.err = zmvu_pkg::ERR_BOUNDS;
                        end
                    end
                    zmvu_pkg::OP_RD_WORD: begin
                        if (i_sts.ptr_word_ok) begin
                            o_cmd.mem_rd   = 1'b1;
                            o_cmd.addr_sel = zmvu_pkg::SEL_PTR;
                            n_state        = S_W1;
                        end else begin
                            o_cmd.fin = 1'b1;
                            o_cmd.err = zmvu_pkg::ERR_BOUNDS;
                        end
                    end
                    zmvu_pkg::OP_WR_BYTE: begin
                        o_cmd.fin = 1'b1;
                        if (i_sts.ptr_zero) begin
                            o_cmd.err = zmvu_pkg::ERR_ZERO;
                        end else if (!i_sts.ptr_byte_ok) begin
                            o_cmd.err = zmvu_pkg::ERR_BOUNDS;
                        end else begin
                            o_cmd.mem_wr   = 1'b1;
                            o_cmd.addr_sel = zmvu_pkg::SEL_PTR;
                        end
                    end
                    zmvu_pkg::OP_WR_WORD: begin
                        if (i_sts.ptr_zero) begin
                            o_cmd.fin = 1'b1;
                            o_cmd.err = zmvu_pkg::ERR_ZERO;
                        end else if (!i_sts.ptr_word_ok) begin
                            o_cmd.fin = 1'b1;
                            o_cmd.err = zmvu_pkg::ERR_BOUNDS;
                        end else begin
                            o_cmd.mem_wr   = 1'b1;
                            o_cmd.addr_sel = zmvu_pkg::SEL_PTR;
                            o_cmd.byte_hi  = 1'b1;
                            n_state        = S_WL;
                        end
                    end
                    zmvu_pkg::OP_RD_VAR, zmvu_pkg::OP_WR_VAR: begin
                        if (i_sts.var_stack) begin
                            if (i_sts.op == zmvu_pkg::OP_RD_VAR) begin
                                if (i_sts.stk_empty) begin
                                    o_cmd.fin = 1'b1;
                                    o_cmd.err = zmvu_pkg::ERR_EMPTY;
                                end else begin
                                    o_cmd.stk_pop = 1'b1;
                                    n_state       = S_SP;
                                end
                            end else begin
                                o_cmd.fin = 1'b1;
                                if (i_sts.stk_full) begin
                                    o_cmd.err = zmvu_pkg::ERR_FULL;
                                end else begin
                                    o_cmd.stk_push = 1'b1;
                                end
                            end
                        end else if (i_sts.var_local) begin
                            o_cmd.fin = 1'b1;
                            if (!i_sts.local_ok) begin
                                o_cmd.err = zmvu_pkg::ERR_BOUNDS;
                            end else if (i_sts.op == zmvu_pkg::OP_RD_VAR) begin
                                o_cmd.res_sel = zmvu_pkg::RES_LOCAL;
                            end else begin
                                o_cmd.loc_wr = 1'b1;
                            end
                        end else begin
                            if (i_sts.base_ok) begin
                                o_cmd.mem_rd   = 1'b1;
                                o_cmd.addr_sel = zmvu_pkg::SEL_BASE_HI;
                                n_state        = S_G1;
                            end else begin
                                o_cmd.fin = 1'b1;
                                o_cmd.err = zmvu_pkg::ERR_BOUNDS;
                            end
                        end
                    end
                    default: begin
                        if (i_sts.rev_ok) begin
                            o_cmd.mem_rd   = 1'b1;
                            o_cmd.addr_sel = zmvu_pkg::SEL_ZERO;
                            n_state        = S_UN;
                        end else begin
                            o_cmd.fin = 1'b1;
                            o_cmd.err = zmvu_pkg::ERR_BOUNDS;
                        end
                    end
                endcase
            end
            S_RB: begin
                o_cmd.fin     = 1'b1;
                o_cmd.res_sel = zmvu_pkg::RES_BYTE;
                n_state       = S_IDLE;
            end
            S_W1: begin
                o_cmd.cap_hi   = 1'b1;
                o_cmd.mem_rd   = 1'b1;
                o_cmd.addr_sel = zmvu_pkg::SEL_PTR1;
                n_state        = S_W2;
            end
            S_W2: begin
                o_cmd.fin     = 1'b1;
                o_cmd.res_sel = zmvu_pkg::RES_WORD;
                n_state       = S_IDLE;
            end
            S_WL: begin
                o_cmd.mem_wr   = 1'b1;
                o_cmd.addr_sel = zmvu_pkg::SEL_PTR1;
                o_cmd.fin      = 1'b1;
                n_state        = S_IDLE;
            end
            S_SP: begin
                o_cmd.fin     = 1'b1;
                o_cmd.res_sel = zmvu_pkg::RES_STACK;
                n_state       = S_IDLE;
            end
            S_G1: begin
                o_cmd.cap_hi   = 1'b1;
                o_cmd.mem_rd   = 1'b1;
                o_cmd.addr_sel = zmvu_pkg::SEL_BASE_LO;
                n_state        = S_G2;
            end
            S_G2: begin
                // form the global's address from the table base
                o_cmd.cap_ptr = 1'b1;
                n_state       = S_G3;
            end
            S_G3: begin
                if ((i_sts.op == zmvu_pkg::OP_WR_VAR) && i_sts.ptr_zero) begin
                    o_cmd.fin = 1'b1;
                    o_cmd.err = zmvu_pkg::ERR_ZERO;
                    n_state   = S_IDLE;
                end else if (!i_sts.ptr_word_ok) begin
                    o_cmd.fin = 1'b1;
                    o_cmd.err = zmvu_pkg::ERR_BOUNDS;
                    n_state   = S_IDLE;
                end else if (i_sts.op == zmvu_pkg::OP_RD_VAR) begin
                    o_cmd.mem_rd   = 1'b1;
                    o_cmd.addr_sel = zmvu_pkg::SEL_PTR;
                    n_state        = S_W1;
                end else begin
                    o_cmd.mem_wr   = 1'b1;
                    o_cmd.addr_sel = zmvu_pkg::SEL_PTR;
                    o_cmd.byte_hi  = 1'b1;
                    n_state        = S_WL;
                end
            end
            S_UN: begin
                o_cmd.fin     = 1'b1;
                o_cmd.res_sel = zmvu_pkg::RES_UNPACK;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/zmvu_dp.sv
// ============================================================================
// zmvu_dp
// Datapath: story memory, evaluation stack, locals, checks and result word.
// ============================================================================
`default_nettype none

module zmvu_dp #(
    parameter int MEM_BYTES   = zmvu_pkg::DEF_MEM_BYTES,
    parameter int STACK_DEPTH = zmvu_pkg::DEF_STACK_DEPTH,
    parameter int LOCAL_COUNT = zmvu_pkg::DEF_LOCAL_COUNT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire zmvu_pkg::t_in               i_in,
    input  wire logic                        i_cfg_we,
    input  wire logic [zmvu_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  wire zmvu_pkg::t_cmd              i_cmd,
    output zmvu_pkg::t_sts                   o_sts,
    output logic                             o_valid,
    output zmvu_pkg::t_out                   o_out
);

    localparam int MEM_AW = $clog2(MEM_BYTES);
    localparam int SIDX_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int LIDX_W = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1;
    localparam int PW     = zmvu_pkg::PTR_W;
    localparam int DW     = zmvu_pkg::DATA_W;

    localparam logic [PW-1:0]    MEM_SIZE  = PW'(MEM_BYTES);
    localparam logic [CNT_W-1:0] STK_LIMIT = CNT_W'(STACK_DEPTH);
    localparam logic [7:0]       LOC_LIMIT = 8'(LOCAL_COUNT);

    // Storage
    logic [7:0]  mem   [MEM_BYTES];
    logic [15:0] stk   [STACK_DEPTH];
    logic [15:0] r_loc [LOCAL_COUNT];

    // Latched word and working registers
    logic [2:0]       r_op;
    logic [7:0]       r_var;
    logic [15:0]      r_val;
    logic [PW-1:0]    r_ptr;
    logic [7:0]       r_hi;
    logic [7:0]       r_rdata;
    logic [15:0]      r_sdata;
    logic [PW-1:0]    r_eff;
    logic [CNT_W-1:0] r_count;
    logic             r_valid;
    logic [DW-1:0]    r_data;
    logic [2:0]       r_err;

    logic [PW-1:0]     w_maddr;
    logic [PW-1:0]     w_ptr1;
    logic [7:0]        w_wbyte;
    logic [CNT_W-1:0]  w_cnt_dec;
    logic [LIDX_W-1:0] w_lidx;
    logic [DW-1:0]     w_res;
    logic [8:0]        w_goff;

    assign w_ptr1    = r_ptr + PW'(1);
    assign w_cnt_dec = r_count - CNT_W'(1);
    assign w_lidx    = LIDX_W'(r_var[3:0] - 4'd1);
    assign w_wbyte   = i_cmd.byte_hi ? r_val[15:8] : r_val[7:0];
    assign w_goff    = {r_var - 8'd16, 1'b0};

    always_comb begin
        case (i_cmd.addr_sel)
            zmvu_pkg::SEL_PTR:     w_maddr = r_ptr;
            zmvu_pkg::SEL_PTR1:    w_maddr = w_ptr1;
            zmvu_pkg::SEL_BASE_HI: w_maddr = zmvu_pkg::GLOBAL_BASE;
            zmvu_pkg::SEL_BASE_LO: w_maddr = zmvu_pkg::GLOBAL_BASE + PW'(1);
            default:               w_maddr = '0;
        endcase
    end

    // Story memory: one byte port, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            mem[w_maddr[MEM_AW-1:0]] <= w_wbyte;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= mem[w_maddr[MEM_AW-1:0]];
        end
    end

    // Evaluation stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.stk_push) begin
            stk[r_count[SIDX_W-1:0]] <= r_val;
        end
        if (i_cmd.stk_pop) begin
            r_sdata <= stk[w_cnt_dec[SIDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.stk_push) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.stk_pop) begin
            r_count <= w_cnt_dec;
        end
    end

    // Locals, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LOCAL_COUNT; i++) begin
                r_loc[i] <= '0;
            end
        end else if (i_cmd.loc_wr) begin
            r_loc[w_lidx] <= r_val;
        end
    end

    // Effective size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff <= '0;
        end else if (i_cfg_we) begin
            r_eff <= (i_cfg_wdata < MEM_SIZE) ? i_cfg_wdata : MEM_SIZE;
        end
    end

    // Latched word, byte capture and pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_in.op;
            r_var <= i_in.variable;
            r_val <= i_in.value;
            r_ptr <= PW'(i_in.address);
        end else if (i_cmd.cap_ptr) begin
            r_ptr <= PW'({r_hi, r_rdata}) + PW'(w_goff);
        end
        if (i_cmd.cap_hi) begin
            r_hi <= r_rdata;
        end
    end

    // Status for the sequencer
    always_comb begin
        o_sts.op          = r_op;
        o_sts.ptr_zero    = (r_ptr == '0);
        o_sts.ptr_in_mem  = (r_ptr < MEM_SIZE);
        o_sts.ptr_byte_ok = (r_ptr < r_eff);
        o_sts.ptr_word_ok = ({1'b0, w_ptr1} < {1'b0, r_eff}) && (w_ptr1 != '0);
        o_sts.var_stack   = (r_var == 8'd0);
        o_sts.var_local   = (r_var < 8'd16);
        o_sts.local_ok    = (r_var <= LOC_LIMIT);
        o_sts.stk_empty   = (r_count == '0);
        o_sts.stk_full    = (r_count >= STK_LIMIT);
        o_sts.base_ok     = ((zmvu_pkg::GLOBAL_BASE + PW'(1)) < r_eff);
        o_sts.rev_ok      = (r_eff != '0);
    end

    // Result selection
    always_comb begin
        case (i_cmd.res_sel)
            zmvu_pkg::RES_BYTE:  w_res = DW'(r_rdata);
            zmvu_pkg::RES_WORD:  w_res = DW'({r_hi, r_rdata});
            zmvu_pkg::RES_STACK: w_res = DW'(r_sdata);
            zmvu_pkg::RES_LOCAL: w_res = DW'(r_loc[w_lidx]);
            zmvu_pkg::RES_UNPACK: begin
                if ((r_rdata >= 8'd1) && (r_rdata <= 8'd3)) begin
                    w_res = DW'({r_val, 1'b0});
                end else if ((r_rdata >= 8'd4) && (r_rdata <= 8'd7)) begin
                    w_res = DW'({r_val, 2'b00});
                end else if (r_rdata == 8'd8) begin
                    w_res = DW'({r_val, 3'b000});
                end else begin
                    w_res = '0;
                end
            end
            default: w_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_data <= (i_cmd.err == zmvu_pkg::ERR_OK) ? w_res : '0;
            r_err  <= i_cmd.err;
        end
    end

    assign o_valid    = r_valid;
    assign o_out.data  = r_data;
    assign o_out.error = r_err;

endmodule

`default_nettype wire

### src/zmvu_checker.sv
// ============================================================================
// zmvu_checker
// Port-level checks on the command and result words, bound to the top level.
// ============================================================================
`default_nettype none

module zmvu_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic                       o_valid,
    input wire zmvu_pkg::t_out             o_out
);

    // an accepted command holds the block busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted command");

    // a result always retires the command: the block is free again
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while still busy");

    // results never come back to back
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two results in adjacent cycles");

    // an error result carries zero data
    a_err_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_out.error != zmvu_pkg::ERR_OK)) |-> (o_out.data == '0))
        else $error("error result with nonzero data");

    // only defined error codes appear
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_out.error == zmvu_pkg::ERR_OK) ||
                     (o_out.error == zmvu_pkg::ERR_BOUNDS) ||
                     (o_out.error == zmvu_pkg::ERR_ZERO) ||
                     (o_out.error == zmvu_pkg::ERR_EMPTY) ||
                     (o_out.error == zmvu_pkg::ERR_FULL)))
        else $error("undefined error code");

endmodule

bind zmachine_memory_variable_unit_top zmvu_checker u_zmvu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_out       (o_out)
);

`default_nettype wire

### sim/tb.sv
// ============================================================================
// tb
// Self-checking bench for the Z-machine memory and variable unit.
// Drives command words through the start/busy handshake, predicts every
// result from a local copy of the story image, stack, locals and ram_size,
// and checks each strobed result word in order. A short table of directed
// words is followed by random words under several ram_size settings and a
// stack drain-and-fill pass.
// ============================================================================

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import zmvu_pkg::*;

    localparam int MEM_SZ       = DEF_MEM_BYTES;
    localparam int STK_MAX      = DEF_STACK_DEPTH;
    localparam int LOC_MAX      = DEF_LOCAL_COUNT;
    localparam int HDR_BASE     = GLOBAL_BASE;   // header word with the globals base
    localparam int FIRST_GLOBAL = 16;
    localparam int STALL_LIMIT  = 400;           // cycles with neither accept nor result
    localparam int DRAIN_CYCLES = 16;            // idle cycles after the last result

    // Random word mixes
    localparam int MIX_GENERAL = 0;
    localparam int MIX_PUSH    = 1;
    localparam int MIX_POP     = 2;

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in         i_in;
    logic        i_cfg_we;
    logic [19:0] i_cfg_wdata;
    logic        o_valid;
    t_out        o_out;

    zmachine_memory_variable_unit_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_out       (o_out)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor state: our own image of the story, stack, locals and size.
    // img_set marks bytes that were ever loaded or written; reads of anything
    // else are steered away from, since the hardware leaves them undefined.
    // ------------------------------------------------------------------------
    bit [7:0]  story_img [MEM_SZ];
    bit        img_set   [MEM_SZ];
    bit [15:0] stk_mem   [STK_MAX];
    bit [15:0] loc_vars  [LOC_MAX];
    int        stk_depth;
    int        stk_peak;
    bit [19:0] ram_cfg;

    t_out      result_q [$];     // expected result words, oldest first
    int        err_hits [8];     // predicted outcomes by error code
    int        words_sent;
    int        words_checked;
    int        mismatches;
    int        size_writes;
    int        burst_left;
    int        quiet_cycles;

    function automatic int unsigned mem_limit();
        return (ram_cfg < MEM_SZ) ? int'(ram_cfg) : MEM_SZ;
    endfunction

    function automatic bit [15:0] word_at(input int unsigned a);
        return {story_img[a], story_img[a + 1]};
    endfunction

    function automatic void put_byte(input int unsigned a, input bit [7:0] b);
        story_img[a] = b;
        img_set[a]   = 1'b1;
    endfunction

    function automatic void put_word(input int unsigned a, input bit [15:0] v);
        put_byte(a, v[15:8]);
        put_byte(a + 1, v[7:0]);
    endfunction

    // Apply one command word to the predictor state and return its result.
    function automatic t_out mem_var_step(input t_in w);
        t_out        r;
        int unsigned a, lim, tgt, dat;
        bit [7:0]    rev;
        bit [2:0]    err;
        a   = w.address;
        lim = mem_limit();
        dat = 0;
        err = ERR_OK;
        case (w.op)
            // raw load ignores ram_size and address 0; every 19-bit address fits
            OP_LOAD:    put_byte(a, w.value[7:0]);
            OP_RD_BYTE: if (a < lim) dat = story_img[a]; else err = ERR_BOUNDS;
            OP_RD_WORD: if (a + 1 < lim) dat = word_at(a); else err = ERR_BOUNDS;
            OP_WR_BYTE: begin
                if (a == 0) err = ERR_ZERO;
                else if (a >= lim) err = ERR_BOUNDS;
                else put_byte(a, w.value[7:0]);
            end
            OP_WR_WORD: begin
                if (a == 0) err = ERR_ZERO;
                else if (a + 1 >= lim) err = ERR_BOUNDS;
                else put_word(a, w.value);
            end
            OP_RD_VAR, OP_WR_VAR: begin
                if (w.variable == 0) begin
                    // evaluation stack: pop on read, push on write
                    if (w.op == OP_RD_VAR) begin
                        if (stk_depth == 0) err = ERR_EMPTY;
                        else begin
                            stk_depth--;
                            dat = stk_mem[stk_depth];
                        end
                    end else if (stk_depth >= STK_MAX) begin
                        err = ERR_FULL;
                    end else begin
                        stk_mem[stk_depth] = w.value;
                        stk_depth++;
                        if (stk_depth > stk_peak) stk_peak = stk_depth;
                    end
                end else if (w.variable < FIRST_GLOBAL) begin
                    if (w.variable > LOC_MAX) err = ERR_BOUNDS;
                    else if (w.op == OP_RD_VAR) dat = loc_vars[w.variable - 1];
                    else loc_vars[w.variable - 1] = w.value;
                end else if (HDR_BASE + 1 >= lim) begin
                    err = ERR_BOUNDS;
                end else begin
                    tgt = word_at(HDR_BASE) + 2 * (w.variable - FIRST_GLOBAL);
                    if (w.op == OP_WR_VAR && tgt == 0) err = ERR_ZERO;
                    else if (tgt + 1 >= lim) err = ERR_BOUNDS;
                    else if (w.op == OP_RD_VAR) dat = word_at(tgt);
                    else put_word(tgt, w.value);
                end
            end
            default: begin
                // unpack: scale by the story revision held in byte 0
                if (lim == 0) begin
                    err = ERR_BOUNDS;
                end else begin
                    rev = story_img[0];
                    if (rev >= 1 && rev <= 3) dat = 32'(w.value) << 1;
                    else if (rev >= 4 && rev <= 7) dat = 32'(w.value) << 2;
                    else if (rev == 8) dat = 32'(w.value) << 3;
                end
            end
        endcase
        r.error = err;
        r.data  = (err == ERR_OK) ? 19'(dat) : '0;
        return r;
    endfunction

    // First never-written byte that this word would read, or -1.
    function automatic int unfilled_byte(input t_in w);
        int unsigned a, lim, tgt;
        a   = w.address;
        lim = mem_limit();
        case (w.op)
            OP_RD_BYTE: if (a < lim && !img_set[a]) return a;
            OP_RD_WORD: begin
                if (a + 1 < lim) begin
                    if (!img_set[a]) return a;
                    if (!img_set[a + 1]) return a + 1;
                end
            end
            OP_RD_VAR, OP_WR_VAR: begin
                if (w.variable >= FIRST_GLOBAL && HDR_BASE + 1 < lim) begin
                    if (!img_set[HDR_BASE]) return HDR_BASE;
                    if (!img_set[HDR_BASE + 1]) return HDR_BASE + 1;
                    tgt = word_at(HDR_BASE) + 2 * (w.variable - FIRST_GLOBAL);
                    if (w.op == OP_RD_VAR && tgt + 1 < lim) begin
                        if (!img_set[tgt]) return tgt;
                        if (!img_set[tgt + 1]) return tgt + 1;
                    end
                end
            end
            OP_UNPACK: if (lim > 0 && !img_set[0]) return 0;
            default: ;
        endcase
        return -1;
    endfunction

    // Keep the revision byte and the globals base small so that unpack sees
    // every revision class and globals land near the bottom of the image.
    function automatic bit [15:0] pick_value(input bit [18:0] a);
        if (a == 0) return 16'($urandom_range(0, 10));
        if (a == HDR_BASE) return 16'($urandom_range(0, 1));
        return 16'($urandom);
    endfunction

    function automatic t_in make_word(input int mix);
        t_in         w;
        int          pick;
        int unsigned lim;
        pick = $urandom_range(0, 99);
        lim  = mem_limit();
        w.op = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 9))
            0, 1:    w.variable = 8'd0;
            2, 3:    w.variable = 8'($urandom_range(1, 15));
            9:       w.variable = 8'($urandom);
            default: w.variable = 8'($urandom_range(FIRST_GLOBAL, FIRST_GLOBAL + 15));
        endcase
        case ($urandom_range(0, 19))
            0, 1:    w.address = 19'($urandom_range(0, 1) + HDR_BASE * $urandom_range(0, 1));
            2, 3:    w.address = 19'h7FFFF - 19'($urandom_range(0, 15));
            4, 5:    w.address = 19'(lim - $urandom_range(0, 3));   // straddle the size
            6, 7:    w.address = 19'($urandom);
            default: w.address = 19'($urandom_range(0, 255));
        endcase
        w.value = pick_value(w.address);
        if (mix == MIX_PUSH && pick < 90) begin
            w.op       = OP_WR_VAR;
            w.variable = 8'd0;
        end
        if (mix == MIX_POP && pick < 90) begin
            w.op       = OP_RD_VAR;
            w.variable = 8'd0;
        end
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table: typed rows carry an expectation that is plain from the
    // spec; the rest are checked against the predictor.
    // ------------------------------------------------------------------------
    typedef struct packed {
        bit        is_cfg;
        bit        typed;
        t_in       w;
        t_out      res;
        bit [19:0] cfg_val;
    } t_probe_row;

    function automatic t_probe_row cmd(input bit [2:0] op, input bit [18:0] a,
                                       input bit [7:0] v, input bit [15:0] val);
        t_probe_row p;
        p       = '0;
        p.w     = '{op: op, address: a, variable: v, value: val};
        return p;
    endfunction

    function automatic t_probe_row cmd_exp(input bit [2:0] op, input bit [18:0] a,
                                           input bit [7:0] v, input bit [15:0] val,
                                           input bit [18:0] d, input bit [2:0] e);
        t_probe_row p;
        p       = cmd(op, a, v, val);
        p.typed = 1'b1;
        p.res   = '{data: d, error: e};
        return p;
    endfunction

    function automatic t_probe_row cfg_row(input bit [19:0] v);
        t_probe_row p;
        p         = '0;
        p.is_cfg  = 1'b1;
        p.cfg_val = v;
        return p;
    endfunction

    t_probe_row plan [$];

    // ------------------------------------------------------------------------
    // Stimulus side
    // ------------------------------------------------------------------------

    // Hold the word on i_in with start high until an edge finds busy low,
    // then record what the block owes us for it.
    task automatic issue(input t_in w, input bit typed, input t_out typed_res);
        t_out r;
        start <= 1'b1;
        i_in  <= w;
        do @(posedge i_clk); while (busy);
        r = mem_var_step(w);
        result_q.push_back(typed ? typed_res : r);
        err_hits[r.error]++;
        words_sent++;
    endtask

    // Bursts of back-to-back words separated by random gaps; start stays
    // high across a burst and only drops when a gap is taken.
    task automatic pace(input bit gappy);
        int g;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            g = gappy ? $urandom_range(0, 9) : 0;
            if (g > 0) begin
                start <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Write ram_size only once every outstanding result has come back.
    task automatic set_ram_size(input bit [19:0] v);
        start <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        ram_cfg      = v;
        size_writes++;
    endtask

    task automatic run_phase(input int count, input int mix, input bit gappy);
        t_in w;
        int  hole;
        repeat (count) begin
            w    = make_word(mix);
            hole = unfilled_byte(w);
            // fill the missing byte first; the read comes around again later
            if (hole >= 0) begin
                w.op      = OP_LOAD;
                w.address = 19'(hole);
                w.value   = pick_value(19'(hole));
            end
            pace(gappy);
            issue(w, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker and watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (result_q.size() == 0) begin
                    $display("%0t: result with nothing outstanding, got data %05h error %0d",
                             $time, o_out.data, o_out.error);
                    mismatches++;
                end else begin
                    want = result_q.pop_front();
                    if (o_out.data !== want.data || o_out.error !== want.error) begin
                        $display("%0t: mismatch, expected data %05h error %0d, got data %05h error %0d",
                                 $time, want.data, want.error, o_out.data, o_out.error);
                        mismatches++;
                    end
                    words_checked++;
                end
            end
            // count edges where neither side moved a word
            if ((start && !busy) || o_valid) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("%0t: no progress for %0d cycles, %0d results outstanding",
                             $time, quiet_cycles, result_q.size());
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        bit [19:0] sizes [8];
        int        base_full;
        int        base_empty;

        start       <= 1'b0;
        i_in        <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        i_rst_n     <= 1'b0;
        stk_depth    = 0;
        stk_peak     = 0;
        ram_cfg      = '0;
        burst_left   = 0;
        quiet_cycles = 0;
        words_sent   = 0;
        words_checked = 0;
        mismatches   = 0;
        size_writes  = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        plan = '{
            // ram_size is zero out of reset: nothing is in range
            cmd_exp(OP_RD_BYTE, 19'd0, 8'd0, 16'h0000, 19'd0, ERR_BOUNDS),
            cmd_exp(OP_UNPACK, 19'd0, 8'd0, 16'h0001, 19'd0, ERR_BOUNDS),
            cmd_exp(OP_RD_VAR, 19'd0, 8'd0, 16'h0000, 19'd0, ERR_EMPTY),
            cmd_exp(OP_RD_VAR, 19'd0, 8'd1, 16'h0000, 19'd0, ERR_OK),
            cmd_exp(OP_RD_VAR, 19'd0, 8'd255, 16'h0000, 19'd0, ERR_BOUNDS),
            // the address-zero check wins over bounds
            cmd_exp(OP_WR_BYTE, 19'd0, 8'd0, 16'hFFFF, 19'd0, ERR_ZERO),
            cmd_exp(OP_WR_WORD, 19'h7FFFF, 8'd0, 16'hFFFF, 19'd0, ERR_BOUNDS),
            // raw load ignores both the size and address zero
            cmd_exp(OP_LOAD, 19'd0, 8'd0, 16'h0008, 19'd0, ERR_OK),
            cmd_exp(OP_LOAD, 19'h7FFFF, 8'd0, 16'h00FF, 19'd0, ERR_OK),
            cmd_exp(OP_LOAD, 19'd12, 8'd0, 16'hFF00, 19'd0, ERR_OK),
            cmd_exp(OP_LOAD, 19'd13, 8'd0, 16'h0000, 19'd0, ERR_OK),
            // oversize setting clamps to the full memory
            cfg_row(20'hFFFFF),
            cmd_exp(OP_UNPACK, 19'd0, 8'd0, 16'hFFFF, 19'h7FFF8, ERR_OK),
            cmd_exp(OP_RD_BYTE, 19'h7FFFF, 8'd0, 16'h0000, 19'h000FF, ERR_OK),
            cmd_exp(OP_RD_WORD, 19'h7FFFF, 8'd0, 16'h0000, 19'd0, ERR_BOUNDS),
            // globals base is zero, so global 16 sits on address zero
            cmd_exp(OP_WR_VAR, 19'd0, 8'd16, 16'h1234, 19'd0, ERR_ZERO),
            cmd(OP_WR_WORD, 19'd12, 8'd0, 16'h0040),
            cmd(OP_WR_VAR, 19'd0, 8'd255, 16'hFFFF),
            cmd(OP_RD_VAR, 19'd0, 8'd255, 16'h0000),
            cmd(OP_WR_VAR, 19'd0, 8'd0, 16'hA5A5),
            cmd(OP_RD_VAR, 19'd0, 8'd0, 16'h0000),
            cmd(OP_WR_VAR, 19'd0, 8'd15, 16'h8001),
            cmd(OP_RD_VAR, 19'd0, 8'd15, 16'h0000),
            cmd(OP_LOAD, 19'd0, 8'd0, 16'h0003),
            cmd(OP_UNPACK, 19'd0, 8'd0, 16'h8000),
            // just room for the header word, not for the globals table
            cfg_row(20'd14),
            cmd_exp(OP_RD_VAR, 19'd0, 8'd16, 16'h0000, 19'd0, ERR_BOUNDS),
            cmd(OP_RD_WORD, 19'd12, 8'd0, 16'h0000),
            cmd_exp(OP_WR_BYTE, 19'd14, 8'd0, 16'h00AA, 19'd0, ERR_BOUNDS)
        };

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                set_ram_size(plan[i].cfg_val);
            end else begin
                pace(1'b1);
                issue(plan[i].w, plan[i].typed, plan[i].res);
            end
        end

        // Random words under a spread of sizes; odd phases run without gaps.
        sizes = '{20'h80000, 20'd0, 20'd1, 20'd14, 20'd300, 20'h7FFFF, 20'hFFFFF,
                  20'($urandom_range(16, 20'hFFFFF))};
        foreach (sizes[p]) begin
            set_ram_size(sizes[p]);
            run_phase(40, MIX_GENERAL, p % 2 == 0);
        end

        // Drain the stack past empty, then drive it into full.
        set_ram_size(20'h80000);
        base_empty = err_hits[ERR_EMPTY];
        while (err_hits[ERR_EMPTY] < base_empty + 6) run_phase(16, MIX_POP, 1'b1);
        base_full = err_hits[ERR_FULL];
        while (err_hits[ERR_FULL] < base_full + 6) run_phase(16, MIX_PUSH, 1'b1);

        // Drop start, let every result come home, then idle a little longer.
        start <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d command words sent, %0d results checked, %0d ram_size writes, stack peak %0d",
                 words_sent, words_checked, size_writes, stk_peak);
        $display("outcomes: ok %0d, bounds %0d, address zero %0d, stack empty %0d, stack full %0d",
                 err_hits[ERR_OK], err_hits[ERR_BOUNDS], err_hits[ERR_ZERO],
                 err_hits[ERR_EMPTY], err_hits[ERR_FULL]);
        if (mismatches == 0 && result_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### zmachine_memory_variable_unit_top.f
src/zmvu_pkg.sv
src/zmvu_ctrl.sv
src/zmvu_dp.sv
src/zmachine_memory_variable_unit_top.sv
src/zmvu_checker.sv
sim/tb.sv
